>>> design/ismt_pkg.sv
// shared types and constants for the integer set membership table
// no dependencies; used by every module of the block
package ismt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 2;
  localparam int COUNT_W  = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> design/ismt_ctrl.sv
// controller for the set table: accepts one command, then executes it
// depends on ismt_pkg
module ismt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  ismt_pkg::dp_status_t   status,
  output ismt_pkg::ctrl_cmd_t    cmd
);

  ismt_pkg::state_t state_r;
  ismt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ismt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ismt_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = ismt_pkg::ST_EXEC;
      end
      ismt_pkg::ST_EXEC: begin
        // wait here while the previous result is still held
        if (status.out_free) state_nxt = ismt_pkg::ST_IDLE;
      end
      default: state_nxt = ismt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ismt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ismt_pkg::ST_EXEC: begin
        cmd.exec = status.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

>>> design/ismt_dp.sv
// datapath: entry registers, parallel compare, free-slot encoder, result register
// depends on ismt_pkg
module ismt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ismt_pkg::ctrl_cmd_t                 cmd,
  output ismt_pkg::dp_status_t                status,
  input  logic [ismt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ismt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);

  logic [ismt_pkg::CMD_W-1:0]   op_r;
  logic [ismt_pkg::VAL_W-1:0]   value_r;
  logic                         last_r;

  logic [ismt_pkg::VAL_W-1:0]   entry_r [ismt_pkg::CAPACITY];
  logic [ismt_pkg::CAPACITY-1:0] valid_r;
  logic [ismt_pkg::CNT_W-1:0]   count_r;

  logic                         out_valid_r;
  logic                         was_member_r;
  logic                         full_r;
  logic [ismt_pkg::COUNT_W-1:0] elem_r;
  logic                         batch_end_r;

  logic [ismt_pkg::CAPACITY-1:0] hit;
  logic                          hit_any;
  logic                          table_full;
  logic [ismt_pkg::IDX_W-1:0]    free_idx;
  logic                          do_add;
  logic                          do_remove;
  logic [ismt_pkg::CNT_W-1:0]    count_nxt;

  always_comb begin
    for (int i = 0; i < ismt_pkg::CAPACITY; i++) begin
      hit[i] = valid_r[i] && (entry_r[i] == value_r);
    end
  end

  assign hit_any    = |hit;
  assign table_full = &valid_r;

  // lowest-numbered free entry
  always_comb begin
    free_idx = '0;
    for (int i = ismt_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = ismt_pkg::IDX_W'(i);
    end
  end

  assign do_add    = (op_r == ismt_pkg::CMD_ADD) && !hit_any && !table_full;
  assign do_remove = (op_r == ismt_pkg::CMD_REMOVE) && hit_any;

  always_comb begin
    priority if (do_add) begin
      count_nxt = count_r + ismt_pkg::CNT_W'(1);
    end else if (do_remove) begin
      count_nxt = count_r - ismt_pkg::CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  assign status.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tdata[ismt_pkg::CMD_W-1:0];
      value_r <= in_tdata[ismt_pkg::CMD_W +: ismt_pkg::VAL_W];
      last_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_add) begin
      entry_r[free_idx] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
      if (do_add) begin
        valid_r[free_idx] <= 1'b1;
      end else if (do_remove) begin
        valid_r <= valid_r & ~hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      was_member_r <= hit_any;
      full_r       <= (op_r == ismt_pkg::CMD_ADD) && !hit_any && table_full;
      elem_r       <= ismt_pkg::COUNT_W'(count_nxt);
      batch_end_r  <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, elem_r, full_r, was_member_r};
  assign out_tlast  = batch_end_r;

endmodule

>>> design/integer_set_membership_table_unit.sv
// integer set membership table, top level: controller plus datapath
// each command is taken in the accept state and then executed in the execute state by a
// parallel compare of all entries; no new command enters meanwhile, and execution waits
// while the previous result is held; a finished result waits in the output register
// while the next command is taken; reset (rst_n low, synchronous) clears all valid
// marks, the count and out_tvalid; depends on ismt_pkg, ismt_ctrl, ismt_dp
module integer_set_membership_table_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ismt_pkg::IN_TDATA_W-1:0]  in_tdata,   // cmd[1:0], value[33:2], zero pad
  input  logic                             in_tlast,   // batch_last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ismt_pkg::OUT_TDATA_W-1:0] out_tdata,  // was_member, status, element_count[6:2]
  output logic                             out_tlast   // batch_end
);

  ismt_pkg::ctrl_cmd_t  cmd;
  ismt_pkg::dp_status_t status;

  ismt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ismt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> design/ismt_chk.sv
// port-level checks for the set table top level, attached by bind
// depends on ismt_pkg and integer_set_membership_table_unit
module ismt_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ismt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // one command in flight: no transfer in the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // a dropped add was never a member
  a_full_not_member: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0])
    else $error("full status on a present value");

  // a transfer taken while no result is held is followed by its result after the execute state
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("missing result");

endmodule

bind integer_set_membership_table_unit ismt_chk u_ismt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
